>>> hdl/hsbf_pkg.sv
// shared constants and types for the hash slice bloom filter
`timescale 1ns / 1ps
package hsbf_pkg;
  localparam int MAX_FILTER_BITS = 1048576;
  localparam int HASH_BYTES      = 24;
  localparam int MAX_SLICES      = 12;
  localparam int STORE_BYTES     = MAX_FILTER_BITS / 8;
  localparam int ADDR_W          = $clog2(STORE_BYTES);
  localparam int POS_W           = $clog2(MAX_FILTER_BITS + 1);
  localparam int HASH_W          = 8 * HASH_BYTES;
  localparam int BYTE_CNT_W      = $clog2(HASH_BYTES + 1);

  localparam logic [2:0] MODE_ADD   = 3'd0;
  localparam logic [2:0] MODE_MATCH = 3'd1;
  localparam logic [2:0] MODE_WRITE = 3'd2;
  localparam logic [2:0] MODE_READ  = 3'd3;
  localparam logic [2:0] MODE_CLEAR = 3'd4;

  localparam logic CFG_NUM_HASHES  = 1'b0;
  localparam logic CFG_FILTER_BITS = 1'b1;

  typedef struct packed {
    logic [2:0]  mode;
    logic [63:0] hash_low;
    logic [63:0] hash_mid;
    logic [63:0] hash_high;
    logic [16:0] byte_index;
    logic [7:0]  byte_value;
  } in_beat_t;

  typedef struct packed {
    logic       matched;
    logic [7:0] read_value;
  } out_beat_t;

  typedef struct packed {
    logic       index;
    logic [20:0] data;
  } cfg_beat_t;

  // control between sequencer and modulo unit
  typedef struct packed {
    logic       start;
    logic [7:0] digit;
  } mod_cmd_t;
endpackage

>>> hdl/hsbf_if.sv
// valid/ready channel interfaces
`timescale 1ns / 1ps
interface hsbf_in_if import hsbf_pkg::*; ();
  logic     valid;
  logic     ready;
  in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hsbf_out_if import hsbf_pkg::*; ();
  logic      valid;
  logic      ready;
  out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hsbf_cfg_if import hsbf_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/hash_slice_bloom_filter.sv
// top level: sequencer, residue unit and filter store
// add/match: the k slices are probed in turn, each slice reduced digit by digit
// empty filter or unused mode: the result is offered without any probe
// write/read byte: one store access; clear: one store byte per cycle
// one beat in flight: the result is held until taken, next accept in the cycle after
// reset: a clearing pass over the store runs before the first accept
`timescale 1ns / 1ps
module hash_slice_bloom_filter import hsbf_pkg::*; (
  input logic clk,
  input logic rst,
  hsbf_in_if.sink   in_ch,
  hsbf_out_if.source out_ch,
  hsbf_cfg_if.sink  cfg
);
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DIG   = 4'd2;
  localparam logic [3:0] S_WAIT  = 4'd3;
  localparam logic [3:0] S_RD    = 4'd4;
  localparam logic [3:0] S_RDW   = 4'd5;
  localparam logic [3:0] S_UPD   = 4'd6;
  localparam logic [3:0] S_OUT   = 4'd7;
  localparam logic [3:0] S_BRD   = 4'd8;
  localparam logic [3:0] S_BRDW  = 4'd9;
  localparam logic [3:0] S_START = 4'd10;

  logic [3:0]             state;
  logic [3:0]             num_hashes;
  logic [20:0]            filter_bits;
  in_beat_t               item;
  logic [HASH_W-1:0]      hash;
  logic [3:0]             k;
  logic [BYTE_CNT_W-1:0]  width;
  logic [BYTE_CNT_W-1:0]  start_b;
  logic [BYTE_CNT_W-1:0]  j;
  logic [3:0]             n;
  logic [POS_W-1:0]       m;
  logic [ADDR_W:0]        clr_addr;
  logic                   clr_reply;
  logic                   matched;
  logic [7:0]             read_value;
  mod_cmd_t               cmd;
  logic                   mclr;
  logic [POS_W-1:0]       r;
  logic                   busy;
  logic                   we;
  logic [ADDR_W-1:0]      addr;
  logic [7:0]             wdata;
  logic [7:0]             rdata;
  logic [BYTE_CNT_W-1:0]  bidx;
  logic                   addr_ok;

  // effective k, m and slice width
  always_comb begin
    k = num_hashes;
    if (k == 4'd0) k = 4'd1;
    if (k > 4'(MAX_SLICES)) k = 4'(MAX_SLICES);
    m = (filter_bits > 21'(MAX_FILTER_BITS)) ? POS_W'(MAX_FILTER_BITS)
                                              : POS_W'(filter_bits);
    case (k)
      4'd1:    width = BYTE_CNT_W'(HASH_BYTES / 1);
      4'd2:    width = BYTE_CNT_W'(HASH_BYTES / 2);
      4'd3:    width = BYTE_CNT_W'(HASH_BYTES / 3);
      4'd4:    width = BYTE_CNT_W'(HASH_BYTES / 4);
      4'd5:    width = BYTE_CNT_W'(HASH_BYTES / 5);
      4'd6:    width = BYTE_CNT_W'(HASH_BYTES / 6);
      4'd7:    width = BYTE_CNT_W'(HASH_BYTES / 7);
      4'd8:    width = BYTE_CNT_W'(HASH_BYTES / 8);
      4'd9:    width = BYTE_CNT_W'(HASH_BYTES / 9);
      4'd10:   width = BYTE_CNT_W'(HASH_BYTES / 10);
      4'd11:   width = BYTE_CNT_W'(HASH_BYTES / 11);
      default: width = BYTE_CNT_W'(HASH_BYTES / 12);
    endcase
  end

  assign hash    = {item.hash_high, item.hash_mid, item.hash_low};
  assign bidx    = start_b + j - BYTE_CNT_W'(1);
  assign addr_ok = ({1'b0, item.byte_index} < 18'(STORE_BYTES));

  // config writes
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      num_hashes  <= 4'd1;
      filter_bits <= '0;
    end else if (cfg.valid) begin
      case (cfg.data.index)
        CFG_NUM_HASHES:  num_hashes  <= cfg.data.data[3:0];
        CFG_FILTER_BITS: filter_bits <= cfg.data.data;
        default:         ;
      endcase
    end
  end

  assign in_ch.ready  = (state == S_IDLE);
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.data  = '{matched: matched, read_value: read_value};

  // store port and residue unit control
  always_comb begin
    we        = 1'b0;
    addr      = r[ADDR_W+2:3];
    wdata     = rdata | (8'd1 << r[2:0]);
    cmd.start = (state == S_DIG);
    cmd.digit = hash[bidx*8 +: 8];
    mclr      = 1'b0;
    case (state)
      S_CLEAR: begin
        we    = 1'b1;
        addr  = clr_addr[ADDR_W-1:0];
        wdata = 8'd0;
      end
      S_UPD: we = 1'b1;
      S_BRD: begin
        addr  = item.byte_index[ADDR_W-1:0];
        wdata = item.byte_value;
        we    = (item.mode == MODE_WRITE) && addr_ok;
      end
      S_START: mclr = 1'b1;
      default: ;
    endcase
  end

  hsbf_mod u_mod (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .clr (mclr),
    .m   (m),
    .r   (r),
    .busy(busy)
  );

  hsbf_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store (
    .clk  (clk),
    .we   (we),
    .addr (addr),
    .wdata(wdata),
    .rdata(rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      clr_reply <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          // a clear beat answers once the pass is done, the reset pass does not
          if (clr_addr == (ADDR_W+1)'(STORE_BYTES - 1)) begin
            state <= clr_reply ? S_OUT : S_IDLE;
          end
        end
        S_IDLE: if (in_ch.valid) begin
          item       <= in_ch.data;
          matched    <= (in_ch.data.mode == MODE_MATCH);
          read_value <= '0;
          n          <= '0;
          start_b    <= '0;
          case (in_ch.data.mode)
            MODE_ADD, MODE_MATCH: state <= (m == '0) ? S_OUT : S_START;
            MODE_WRITE, MODE_READ: state <= S_BRD;
            MODE_CLEAR: begin
              clr_addr  <= '0;
              clr_reply <= 1'b1;
              state     <= S_CLEAR;
            end
            default: state <= S_OUT;
          endcase
        end
        S_START: begin
          j     <= width;
          state <= S_DIG;
        end
        S_DIG: state <= S_WAIT;
        S_WAIT: if (!busy) begin
          j <= j - BYTE_CNT_W'(1);
          state <= (j == BYTE_CNT_W'(1)) ? S_RD : S_DIG;
        end
        S_RD: state <= S_RDW;
        S_RDW: begin
          // rdata valid now
          if (item.mode == MODE_ADD) begin
            state <= S_UPD;
          end else if (!rdata[r[2:0]]) begin
            matched <= 1'b0;
            state   <= S_OUT;
          end else if (n == k - 4'd1) begin
            state <= S_OUT;
          end else begin
            n       <= n + 4'd1;
            start_b <= start_b + width;
            state   <= S_START;
          end
        end
        S_UPD: begin
          if (n == k - 4'd1) begin
            state <= S_OUT;
          end else begin
            n       <= n + 4'd1;
            start_b <= start_b + width;
            state   <= S_START;
          end
        end
        S_BRD: state <= S_BRDW;
        S_BRDW: begin
          if (item.mode == MODE_READ && addr_ok) read_value <= rdata;
          state <= S_OUT;
        end
        S_OUT: if (out_ch.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // residue stays below the filter size once a probe is done
  a_res_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RDW) |-> (r < m)) else $error("probe position out of range");
  // a read result appears only for read mode
  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && item.mode != MODE_READ) |-> (read_value == 8'd0))
    else $error("read value outside read mode");
  // no beat accepted during the clearing pass
  a_clear_block: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !in_ch.ready) else $error("accept during clear");
`endif
endmodule

>>> hdl/hsbf_ram.sv
// generic single port ram with registered read
`timescale 1ns / 1ps
module hsbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> hdl/hsbf_mod.sv
// shared residue unit: r = (r*256 + digit) mod m, one digit per call
`timescale 1ns / 1ps
module hsbf_mod import hsbf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  mod_cmd_t         cmd,
  input  logic             clr,
  input  logic [POS_W-1:0] m,
  output logic [POS_W-1:0] r,
  output logic             busy
);
  // acc holds r*256+digit, reduced bit by bit from the top
  logic [POS_W+7:0] acc;
  logic [3:0]       cnt;
  logic [POS_W+7:0] msh;
  logic [POS_W+7:0] cand;

  always_comb begin
    msh  = {8'd0, m} << cnt[2:0];
    cand = acc - msh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      r    <= '0;
      acc  <= '0;
    end else if (clr) begin
      r <= '0;
    end else if (cmd.start) begin
      acc  <= {r, cmd.digit};
      cnt  <= 4'd7;
      busy <= 1'b1;
    end else if (busy) begin
      // restoring subtract of m shifted left by cnt
      if (acc >= msh) begin
        acc <= cand;
      end
      if (cnt == 4'd0) begin
        busy <= 1'b0;
        r    <= (acc >= msh) ? cand[POS_W-1:0] : acc[POS_W-1:0];
      end else begin
        cnt <= cnt - 4'd1;
      end
    end
  end
endmodule
